[src/tsbd_pkg.sv]
// Shared types, codes and constants for the timestamped block stream deframer.
// Used by the input stage, the parser and the top level; depends on nothing.
package tsbd_pkg;

  // Input command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_EOF  = 1'b1;

  // Signature length in bytes and first payload position of the first block
  localparam int          SigLen       = 12;
  localparam logic [47:0] FirstBlockPos = 48'd16;
  localparam logic [31:0] MaxLenReset   = 32'd1048576;
  localparam logic [47:0] HdrStampBytes = 48'd8;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_BLOCK_END = 2'd1,
    KIND_ERROR     = 2'd2,
    KIND_END       = 2'd3
  } kind_t;

  // Error codes
  typedef enum logic [2:0] {
    ERR_BAD_SIG     = 3'd0,
    ERR_SHORT_SIG   = 3'd1,
    ERR_SHORT_HDR   = 3'd2,
    ERR_BAD_LEN     = 3'd3,
    ERR_SHORT_DATA  = 3'd4,
    ERR_SHORT_STAMP = 3'd5
  } err_t;

  // One input request
  typedef struct packed {
    logic       cmd;
    logic [7:0] raw_byte;
  } item_t;

  // One result request
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload;
    logic [31:0] byte_offset;
    logic [47:0] block_pos;
    logic [31:0] block_length;
    logic [31:0] stamp;
    err_t        error_code;
    logic [47:0] payload_total;
  } res_t;

  // Expected signature "FBS 001.000\n"
  function automatic logic [7:0] sig_byte(input logic [3:0] idx);
    logic [7:0] val;
    case (idx)
      4'd0:    val = 8'h46;
      4'd1:    val = 8'h42;
      4'd2:    val = 8'h53;
      4'd3:    val = 8'h20;
      4'd4:    val = 8'h30;
      4'd5:    val = 8'h30;
      4'd6:    val = 8'h31;
      4'd7:    val = 8'h2E;
      4'd8:    val = 8'h30;
      4'd9:    val = 8'h30;
      4'd10:   val = 8'h30;
      4'd11:   val = 8'h0A;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // Padding bytes that bring a length up to a multiple of four
  function automatic logic [1:0] pad_of(input logic [31:0] len);
    return 2'(~len[1:0] + 2'd1);
  endfunction

endpackage

[src/tsbd_if.sv]
// Channel interfaces of the deframer: input requests, result requests and
// the configuration write channel. No dependencies.
interface tsbd_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] raw_byte;

  modport source (output valid, cmd, raw_byte, input ready);
  modport sink   (input valid, cmd, raw_byte, output ready);
endinterface

interface tsbd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload;
  logic [31:0] byte_offset;
  logic [47:0] block_pos;
  logic [31:0] block_length;
  logic [31:0] stamp;
  logic [2:0]  error_code;
  logic [47:0] payload_total;

  modport source (output valid, kind, payload, byte_offset, block_pos, block_length,
                  stamp, error_code, payload_total, input ready);
  modport sink   (input valid, kind, payload, byte_offset, block_pos, block_length,
                  stamp, error_code, payload_total, output ready);
endinterface

interface tsbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[src/tsbd_in_stage.sv]
// Input register of the deframer: captures one request per cycle while
// empty or draining. Depends on tsbd_pkg and tsbd_in_if.
module tsbd_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  tsbd_in_if.sink         in_ch,
  output logic            item_valid,
  output tsbd_pkg::item_t item,
  input  logic            item_take
);
  import tsbd_pkg::*;

  logic  valid_r;
  item_t item_r;
  logic  load;

  // Refill whenever the held request leaves or the register is empty
  assign load        = !valid_r || item_take;
  assign in_ch.ready = load;
  assign item_valid  = valid_r;
  assign item        = item_r;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_ch.valid;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= '{cmd: in_ch.cmd, raw_byte: in_ch.raw_byte};
    end
  end

endmodule

[src/tsbd_parser.sv]
// Deframer state machine and result register: signature check, header,
// payload, padding and timestamp parsing. Depends on tsbd_pkg and tsbd_if.
module tsbd_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  input  tsbd_pkg::item_t item,
  output logic            item_take,
  tsbd_cfg_if.sink        cfg_ch,
  tsbd_out_if.source      out_ch
);
  import tsbd_pkg::*;

  typedef enum logic [2:0] {
    PH_SIG,
    PH_HDR,
    PH_DATA,
    PH_STAMP,
    PH_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  field_count_r, field_count_nxt;
  logic        sig_bad_r, sig_bad_nxt;
  logic [31:0] length_acc_r, length_acc_nxt;
  logic [31:0] offset_count_r, offset_count_nxt;
  logic [31:0] stamp_acc_r, stamp_acc_nxt;
  logic [47:0] next_block_pos_r, next_block_pos_nxt;
  logic [47:0] cur_block_pos_r, cur_block_pos_nxt;
  logic [47:0] total_count_r, total_count_nxt;
  logic [31:0] max_len_r;
  logic        out_valid_r;
  res_t        res_r, res_nxt;
  logic        emit;
  logic        fail;
  err_t        fail_code;
  logic        take;
  logic        fire;
  logic [1:0]  pad;

  // Advance when the result register is free or being drained
  assign take      = !out_valid_r || out_ch.ready;
  assign fire      = item_valid && take;
  assign item_take = take;
  assign pad       = pad_of(length_acc_r);

  assign cfg_ch.ready = 1'b1;

  // Drive the result channel
  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = res_r.kind;
  assign out_ch.payload       = res_r.payload;
  assign out_ch.byte_offset   = res_r.byte_offset;
  assign out_ch.block_pos     = res_r.block_pos;
  assign out_ch.block_length  = res_r.block_length;
  assign out_ch.stamp         = res_r.stamp;
  assign out_ch.error_code    = res_r.error_code;
  assign out_ch.payload_total = res_r.payload_total;

  // Step the parser for one request
  always_comb begin
    phase_nxt          = phase_r;
    field_count_nxt    = field_count_r;
    sig_bad_nxt        = sig_bad_r;
    length_acc_nxt     = length_acc_r;
    offset_count_nxt   = offset_count_r;
    stamp_acc_nxt      = stamp_acc_r;
    next_block_pos_nxt = next_block_pos_r;
    cur_block_pos_nxt  = cur_block_pos_r;
    total_count_nxt    = total_count_r;
    emit               = 1'b0;
    fail               = 1'b0;
    fail_code          = ERR_BAD_SIG;
    res_nxt            = '0;

    if (fire && phase_r != PH_DONE) begin
      if (item.cmd == CMD_EOF) begin
        unique case (phase_r)
          PH_SIG: begin
            fail      = 1'b1;
            fail_code = ERR_SHORT_SIG;
          end
          PH_HDR: begin
            if (field_count_r == 4'd0) begin
              // Clean end at a block boundary
              phase_nxt             = PH_DONE;
              emit                  = 1'b1;
              res_nxt.kind          = KIND_END;
              res_nxt.block_pos     = next_block_pos_r;
              res_nxt.block_length  = length_acc_r;
              res_nxt.payload_total = total_count_r;
            end else begin
              fail      = 1'b1;
              fail_code = ERR_SHORT_HDR;
            end
          end
          PH_DATA: begin
            fail      = 1'b1;
            fail_code = ERR_SHORT_DATA;
          end
          default: begin
            fail      = 1'b1;
            fail_code = ERR_SHORT_STAMP;
          end
        endcase
      end else begin
        unique case (phase_r)
          PH_SIG: begin
            if (sig_byte(field_count_r) != item.raw_byte) begin
              sig_bad_nxt = 1'b1;
            end
            field_count_nxt = field_count_r + 4'd1;
            if (field_count_r == 4'(SigLen - 1)) begin
              if (sig_bad_nxt) begin
                fail      = 1'b1;
                fail_code = ERR_BAD_SIG;
              end else begin
                phase_nxt       = PH_HDR;
                field_count_nxt = 4'd0;
              end
            end
          end
          PH_HDR: begin
            length_acc_nxt  = {length_acc_r[23:0], item.raw_byte};
            field_count_nxt = field_count_r + 4'd1;
            if (field_count_r == 4'd3) begin
              if (length_acc_nxt == 32'd0 || length_acc_nxt > max_len_r) begin
                fail      = 1'b1;
                fail_code = ERR_BAD_LEN;
              end else begin
                phase_nxt         = PH_DATA;
                field_count_nxt   = 4'd0;
                offset_count_nxt  = 32'd0;
                cur_block_pos_nxt = next_block_pos_r;
              end
            end
          end
          PH_DATA: begin
            if (offset_count_r < length_acc_r) begin
              // Payload byte: emit at once
              total_count_nxt  = total_count_r + 48'd1;
              offset_count_nxt = offset_count_r + 32'd1;
              if (offset_count_nxt == length_acc_r && pad == 2'd0) begin
                phase_nxt       = PH_STAMP;
                field_count_nxt = 4'd0;
                stamp_acc_nxt   = 32'd0;
              end
              emit                  = 1'b1;
              res_nxt.kind          = KIND_PAYLOAD;
              res_nxt.payload       = item.raw_byte;
              res_nxt.byte_offset   = offset_count_r;
              res_nxt.block_pos     = cur_block_pos_r;
              res_nxt.block_length  = length_acc_r;
              res_nxt.payload_total = total_count_nxt;
            end else begin
              // Padding byte: drop
              field_count_nxt = field_count_r + 4'd1;
              if (field_count_nxt >= {2'b00, pad}) begin
                phase_nxt       = PH_STAMP;
                field_count_nxt = 4'd0;
                stamp_acc_nxt   = 32'd0;
              end
            end
          end
          PH_STAMP: begin
            stamp_acc_nxt   = {stamp_acc_r[23:0], item.raw_byte};
            field_count_nxt = field_count_r + 4'd1;
            if (field_count_r == 4'd3) begin
              emit                  = 1'b1;
              res_nxt.kind          = KIND_BLOCK_END;
              res_nxt.block_pos     = cur_block_pos_r;
              res_nxt.block_length  = length_acc_r;
              res_nxt.stamp         = stamp_acc_nxt;
              res_nxt.payload_total = total_count_r;
              next_block_pos_nxt    = next_block_pos_r + 48'(length_acc_r)
                                      + 48'(pad) + HdrStampBytes;
              phase_nxt             = PH_HDR;
              field_count_nxt       = 4'd0;
              length_acc_nxt        = 32'd0;
              offset_count_nxt      = 32'd0;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end

      // Terminal error result
      if (fail) begin
        phase_nxt             = PH_DONE;
        emit                  = 1'b1;
        res_nxt               = '0;
        res_nxt.kind          = KIND_ERROR;
        res_nxt.block_pos     = next_block_pos_r;
        res_nxt.block_length  = length_acc_nxt;
        res_nxt.error_code    = fail_code;
        res_nxt.payload_total = total_count_r;
      end
    end
  end

  // Hold parser state, the length limit and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_SIG;
      field_count_r    <= 4'd0;
      sig_bad_r        <= 1'b0;
      length_acc_r     <= 32'd0;
      offset_count_r   <= 32'd0;
      stamp_acc_r      <= 32'd0;
      next_block_pos_r <= FirstBlockPos;
      cur_block_pos_r  <= 48'd0;
      total_count_r    <= 48'd0;
      max_len_r        <= MaxLenReset;
      out_valid_r      <= 1'b0;
    end else begin
      phase_r          <= phase_nxt;
      field_count_r    <= field_count_nxt;
      sig_bad_r        <= sig_bad_nxt;
      length_acc_r     <= length_acc_nxt;
      offset_count_r   <= offset_count_nxt;
      stamp_acc_r      <= stamp_acc_nxt;
      next_block_pos_r <= next_block_pos_nxt;
      cur_block_pos_r  <= cur_block_pos_nxt;
      total_count_r    <= total_count_nxt;
      if (cfg_ch.valid) begin
        max_len_r <= cfg_ch.data;
      end
      if (take) begin
        out_valid_r <= emit;
        res_r       <= res_nxt;
      end
    end
  end

  // Nothing is produced once the stream has ended
  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && phase_r == PH_DONE) |=> !out_valid_r)
    else $error("result produced after end of stream");

  // Terminal results leave the parser finished
  a_terminal_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.kind == KIND_ERROR || res_r.kind == KIND_END))
      |-> phase_r == PH_DONE)
    else $error("terminal result without finished parser");

  // Payload offsets stay inside the declared length
  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.kind == KIND_PAYLOAD) |-> res_r.byte_offset < res_r.block_length)
    else $error("payload offset beyond block length");

  // Signature counter never passes the signature length
  a_sig_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SIG |-> field_count_r < 4'(SigLen))
    else $error("signature counter overrun");

endmodule

[src/timestamped_block_stream_deframer.sv]
// Top level of the timestamped block stream deframer: input register and parser.
// Depends on tsbd_pkg, tsbd_if, tsbd_in_stage and tsbd_parser.
// A result passes through the input register and then the result register.
// Throughput: one request per cycle unless results stall; the input and result
// registers decouple the two channels, and a stalled result holds one entry.
// Reset (synchronous, rst_n low): parser returns to the signature check, the
// block length limit returns to 1048576 bytes and both registers empty.
module timestamped_block_stream_deframer (
  input  logic       clk,
  input  logic       rst_n,
  tsbd_in_if.sink    in_ch,
  tsbd_out_if.source out_ch,
  tsbd_cfg_if.sink   cfg_ch
);
  import tsbd_pkg::*;

  logic  item_valid;
  item_t item;
  logic  item_take;

  tsbd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  tsbd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .cfg_ch     (cfg_ch),
    .out_ch     (out_ch)
  );

endmodule
